>>> src/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit heap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

	localparam int ADDR_W           = 24;
	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int STATUS_W         = 3;

	// request kinds
	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_ZERO      = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_UNKNOWN   = 3'd4;

	// config register byte addresses
	localparam logic [1:0] ADDR_HEAP_LIMIT = 2'd0;
	localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 24'hFFFFFF;

	typedef struct packed {
		logic              req_type;
		logic [ADDR_W-1:0] req_size;
		logic [ADDR_W-1:0] release_address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   user_address;
		logic                from_reuse;
	} rsp_t;

	// request held steady for the cells while a search runs
	typedef struct packed {
		logic              is_release;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} query_t;

	// search wave handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              found;
		logic              last;
		logic [ADDR_W-1:0] start;
	} wave_t;

	// append of a new table entry
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] length;
	} cell_wr_t;

endpackage

`default_nettype wire

>>> src/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator built from a row of table-entry cells.
// ----------------------------------------------------------------------------
// usage:
//   - a request word (req) is taken at a clock edge with start high and busy
//     low; req_type selects allocate or release
//   - each request gives exactly one result word on rsp, marked by done for
//     one cycle; the receiver cannot stall, so nothing is held back
//   - an allocate of zero bytes answers in the cycle after it is taken
//   - every other request sends a search wave down the row of MAX_BLOCKS
//     cells, one cell per cycle; the result appears once the wave has left
//     the last cell, and busy drops in the same cycle as done rises, so the
//     next request can follow right away
//   - a new request is taken only after the previous search wave is through
//   - heap_limit is written over the APB-style port, only while idle; the
//     user must keep to this, as the block itself does not enforce it
//   - reset empties the table, clears the break pointer and sets heap_limit
//     to its maximum; cell contents are left as they are and never read
//     until appended again
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator #(
	parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	// config port
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [1:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// request channel
	input  wire                 start,
	output logic                busy,
	input  wire ffba_pkg::req_t req,
	// result channel
	output logic                done,
	output ffba_pkg::rsp_t      rsp
);
	import ffba_pkg::*;

	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0]     FULL_COUNT = CW'(MAX_BLOCKS);
	localparam logic [ADDR_W-1:0] HDR24      = ADDR_W'(HEADER_BYTES);
	localparam logic [ADDR_W+1:0] HDR26      = (ADDR_W + 2)'(HEADER_BYTES);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] heap_limit_q;
	logic [CW-1:0]     count_q;
	logic [ADDR_W-1:0] break_q;
	query_t            query_q;
	logic              launch_q;
	logic              done_q;
	rsp_t              rsp_q;

	wave_t             wave [MAX_BLOCKS+1];
	wave_t             wave_end;
	cell_wr_t          wr;

	logic              accept;
	logic              zero_req;
	logic              cfg_wr;
	logic [ADDR_W+1:0] new_break;
	logic              finish;
	rsp_t              fin_rsp;
	logic              do_append;
	logic              do_pop;

	// ---------------- config port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_HEAP_LIMIT);
	assign prdata = (paddr == ADDR_HEAP_LIMIT) ? {8'd0, heap_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= HEAP_LIMIT_RST;
		end else if (cfg_wr) begin
			heap_limit_q <= pwdata[ADDR_W-1:0];
		end
	end

	// ---------------- request intake ----------------
	assign busy     = (state_q == S_WALK);
	assign accept   = start && !busy;
	assign zero_req = (req.req_type == REQ_ALLOC) && (req.req_size == '0);

	always_ff @(posedge clk) begin
		if (accept) begin
			query_q <= '{is_release: req.req_type == REQ_RELEASE,
			             size: req.req_size, addr: req.release_address};
		end
	end

	// ---------------- cell row ----------------
	// the wave enters cell 0 in the cycle after intake, with the query settled
	assign wave[0] = '{valid: launch_q, found: 1'b0, last: 1'b0, start: '0};

	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		ffba_cell #(
			.CW           (CW),
			.IDX          (i),
			.HEADER_BYTES (HEADER_BYTES)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.query    (query_q),
			.count    (count_q),
			.wr       (wr),
			.wr_idx   (count_q),
			.wave_in  (wave[i]),
			.wave_out (wave[i+1])
		);
	end

	assign wave_end = wave[MAX_BLOCKS];
	assign finish   = wave_end.valid && (state_q == S_WALK);

	// ---------------- wrap-up when the wave leaves the last cell ----------------
	assign new_break = {2'b00, break_q} + HDR26 + {2'b00, query_q.size};

	always_comb begin
		fin_rsp   = '{status: STAT_OK, user_address: '0, from_reuse: 1'b0};
		do_append = 1'b0;
		do_pop    = 1'b0;
		if (query_q.is_release) begin
			if (wave_end.found) begin
				do_pop = wave_end.last;
			end else begin
				fin_rsp.status = STAT_UNKNOWN;
			end
		end else begin
			priority if (wave_end.found) begin
				// reuse a free block as it is, no split
				fin_rsp.user_address = wave_end.start + HDR24;
				fin_rsp.from_reuse   = 1'b1;
			end else if (count_q == FULL_COUNT) begin
				fin_rsp.status = STAT_FULL;
			end else if (new_break > {2'b00, heap_limit_q}) begin
				fin_rsp.status = STAT_EXHAUSTED;
			end else begin
				fin_rsp.user_address = break_q + HDR24;
				do_append            = 1'b1;
			end
		end
	end

	assign wr = '{en: finish && do_append, start: break_q, length: query_q.size};

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
			break_q  <= '0;
		end else begin
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (zero_req) begin
							done_q <= 1'b1;
						end else begin
							launch_q <= 1'b1;
							state_q  <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (finish) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (do_append) begin
							count_q <= count_q + 1'b1;
							break_q <= new_break[ADDR_W-1:0];
						end else if (do_pop) begin
							count_q <= count_q - 1'b1;
							break_q <= wave_end.start;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result word, payload only
	always_ff @(posedge clk) begin
		if (accept && zero_req) begin
			rsp_q <= '{status: STAT_ZERO, user_address: '0, from_reuse: 1'b0};
		end else if (finish) begin
			rsp_q <= fin_rsp;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// ---------------- assertions ----------------
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while a search is still running");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("block count above table size");

	a_zero_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && zero_req) |=> (done && (rsp.status == STAT_ZERO)))
		else $error("zero size request not answered next cycle");

	a_wave_walk: assert property (@(posedge clk) disable iff (!arst_n)
		wave_end.valid |-> (state_q == S_WALK))
		else $error("search wave left the row while idle");

endmodule

`default_nettype wire

>>> src/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// One table entry of the allocator; checks the passing search wave.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_cell #(
	parameter int CW           = 7,
	parameter int IDX          = 0,
	parameter int HEADER_BYTES = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire ffba_pkg::query_t   query,
	input  wire  [CW-1:0]         count,
	input  wire ffba_pkg::cell_wr_t wr,
	input  wire  [CW-1:0]         wr_idx,
	input  wire ffba_pkg::wave_t    wave_in,
	output ffba_pkg::wave_t       wave_out
);
	import ffba_pkg::*;

	localparam logic [CW-1:0]   MY_IDX  = CW'(IDX);
	localparam logic [CW-1:0]   NXT_IDX = CW'(IDX + 1);
	localparam logic [ADDR_W:0] HDR     = (ADDR_W + 1)'(HEADER_BYTES);

	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] length_q;
	logic              free_q;
	wave_t             wave_q;

	logic in_use;
	logic is_last;
	logic hit_alloc;
	logic hit_rel;
	logic hit;

	assign in_use    = MY_IDX < count;
	assign is_last   = NXT_IDX == count;
	assign hit_alloc = free_q && (length_q >= query.size);
	assign hit_rel   = ({1'b0, start_q} + HDR) == {1'b0, query.addr};
	assign hit       = wave_in.valid && !wave_in.found && in_use &&
	                   (query.is_release ? hit_rel : hit_alloc);

	// entry contents, no reset: only entries below the count are looked at
	always_ff @(posedge clk) begin
		if (wr.en && (wr_idx == MY_IDX)) begin
			start_q  <= wr.start;
			length_q <= wr.length;
			free_q   <= 1'b0;
		end else if (hit) begin
			free_q <= query.is_release;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else if (hit) begin
			wave_q <= '{valid: 1'b1, found: 1'b1, last: is_last, start: start_q};
		end else begin
			wave_q <= wave_in;
		end
	end

	assign wave_out = wave_q;

endmodule

`default_nettype wire
